>>> src/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg
// Constants and shared types for the sensor frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package sfp_pkg;

  localparam int unsigned STORE_DEPTH = 14;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned NUM_RANGES  = 8;

  localparam logic [POS_W-1:0] POS_MAX   = 4'd15;
  localparam logic [POS_W-1:0] POSE_LEN  = 4'd12;
  localparam logic [POS_W-1:0] RANGE_LEN = 4'd14;

  localparam logic [7:0] TERM_BYTE  = 8'h23;
  localparam logic [7:0] SYNC_0     = 8'h45;
  localparam logic [7:0] SYNC_1     = 8'h54;
  localparam logic [7:0] POSE_CODE  = 8'h09;
  localparam logic [7:0] RANGE_CODE = 8'h0C;
  localparam logic [7:0] POSE_ID_0  = 8'h47;
  localparam logic [7:0] POSE_ID_1  = 8'h50;
  localparam logic [7:0] RANGE_ID_0 = 8'h55;
  localparam logic [7:0] RANGE_ID_1 = 8'h49;
  localparam logic [5:0] SUM_MASK   = 6'h3F;
  localparam logic [7:0] SUM_BIAS   = 8'h30;

  localparam int unsigned PAYLOAD_FIRST = 5;
  localparam int unsigned POSE_SUM_IDX  = 11;
  localparam int unsigned RANGE_SUM_IDX = 13;

  localparam logic KIND_POSE  = 1'b0;
  localparam logic KIND_RANGE = 1'b1;

  typedef logic [7:0] byte_t;

endpackage

`default_nettype wire

>>> src/sensor_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// sensor_frame_parser_unit
// Collects serial bytes into a frame and, on the terminator, checks the
// header and checksum and emits one decoded pose or range transaction.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_stall   | rx_byte
//  out     | out_valid / out_stall | frame_kind, left_count, right_count,
//          |                       | heading_raw, range_0 .. range_7
//
//  One byte per cycle while in_stall is low. A terminator byte is decoded
//  from the frame registers in the cycle it is accepted; its result is in the
//  output register the next cycle. in_stall is high only while a result waits
//  and out_stall is high. Reset (synchronous, rst) clears the byte position
//  and the output valid; the frame registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_frame_parser_unit
  import sfp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         rx_byte,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    frame_kind,
  output logic signed [15:0]      left_count,
  output logic signed [15:0]      right_count,
  output logic [15:0]             heading_raw,
  output logic [7:0]              range_0,
  output logic [7:0]              range_1,
  output logic [7:0]              range_2,
  output logic [7:0]              range_3,
  output logic [7:0]              range_4,
  output logic [7:0]              range_5,
  output logic [7:0]              range_6,
  output logic [7:0]              range_7
);

  byte_t            frame_store [STORE_DEPTH];
  logic [POS_W-1:0] byte_position;

  logic             in_take;
  logic             is_term;
  logic             pose_hdr;
  logic             range_hdr;
  logic [5:0]       pose_sum;
  logic [5:0]       range_sum;
  logic             pose_ok;
  logic             range_ok;
  logic             result_next;

  byte_t            ranges [NUM_RANGES];

  assign in_stall = out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;
  assign is_term  = (rx_byte == TERM_BYTE);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (in_take) begin
      if (is_term) begin
        byte_position <= '0;
      end else if (byte_position != POS_MAX) begin
        byte_position <= byte_position + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && !is_term && (byte_position < POS_W'(STORE_DEPTH))) begin
      frame_store[byte_position] <= rx_byte;
    end
  end

  always_comb begin
    pose_hdr  = (frame_store[0] == SYNC_0) && (frame_store[1] == SYNC_1) &&
                (frame_store[2] == POSE_CODE) && (frame_store[3] == POSE_ID_0) &&
                (frame_store[4] == POSE_ID_1);
    range_hdr = (frame_store[0] == SYNC_0) && (frame_store[1] == SYNC_1) &&
                (frame_store[2] == RANGE_CODE) && (frame_store[3] == RANGE_ID_0) &&
                (frame_store[4] == RANGE_ID_1);
    pose_sum  = '0;
    range_sum = '0;
    for (int i = 0; i < 6; i++) begin
      pose_sum = pose_sum + frame_store[PAYLOAD_FIRST + i][5:0];
    end
    for (int i = 0; i < NUM_RANGES; i++) begin
      range_sum = range_sum + frame_store[PAYLOAD_FIRST + i][5:0];
    end
    pose_ok  = (byte_position >= POSE_LEN) && pose_hdr &&
               (({2'b00, pose_sum & SUM_MASK} + SUM_BIAS) == frame_store[POSE_SUM_IDX]);
    range_ok = (byte_position >= RANGE_LEN) && range_hdr &&
               (({2'b00, range_sum & SUM_MASK} + SUM_BIAS) == frame_store[RANGE_SUM_IDX]);
    result_next = in_take && is_term && (pose_ok || range_ok);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (result_next) begin
      if (pose_ok) begin
        frame_kind  <= KIND_POSE;
        left_count  <= {frame_store[5], frame_store[6]};
        right_count <= {frame_store[7], frame_store[8]};
        heading_raw <= {frame_store[9], frame_store[10]};
        for (int i = 0; i < NUM_RANGES; i++) begin
          ranges[i] <= '0;
        end
      end else begin
        frame_kind  <= KIND_RANGE;
        left_count  <= '0;
        right_count <= '0;
        heading_raw <= '0;
        for (int i = 0; i < NUM_RANGES; i++) begin
          ranges[i] <= frame_store[PAYLOAD_FIRST + i];
        end
      end
    end
  end

  assign range_0 = ranges[0];
  assign range_1 = ranges[1];
  assign range_2 = ranges[2];
  assign range_3 = ranges[3];
  assign range_4 = ranges[4];
  assign range_5 = ranges[5];
  assign range_6 = ranges[6];
  assign range_7 = ranges[7];

endmodule

`default_nettype wire

>>> src/sfp_checker.sv
// ----------------------------------------------------------------------------
// sfp_checker
// Port-level checks for the sensor frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_checker
  import sfp_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic [7:0]         rx_byte,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic               frame_kind,
  input wire logic signed [15:0] left_count,
  input wire logic signed [15:0] right_count,
  input wire logic [15:0]        heading_raw,
  input wire logic [7:0]         range_0,
  input wire logic [7:0]         range_1,
  input wire logic [7:0]         range_2,
  input wire logic [7:0]         range_3,
  input wire logic [7:0]         range_4,
  input wire logic [7:0]         range_5,
  input wire logic [7:0]         range_6,
  input wire logic [7:0]         range_7
);

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frame_kind) &&
      $stable(left_count) && $stable(right_count) && $stable(heading_raw) &&
      $stable(range_0) && $stable(range_7))
    else $error("stalled result changed");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  a_result_from_term: assert property (@(posedge clk) disable iff (rst)
    out_valid && !($past(out_valid) && $past(out_stall)) |->
      $past(in_valid) && !$past(in_stall) && ($past(rx_byte) == TERM_BYTE))
    else $error("result without an accepted terminator");

  a_kind_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      ((frame_kind == KIND_POSE) && (range_0 == 8'd0) && (range_1 == 8'd0) &&
       (range_2 == 8'd0) && (range_3 == 8'd0) && (range_4 == 8'd0) &&
       (range_5 == 8'd0) && (range_6 == 8'd0) && (range_7 == 8'd0)) ||
      ((frame_kind == KIND_RANGE) && (left_count == 16'sd0) &&
       (right_count == 16'sd0) && (heading_raw == 16'd0)))
    else $error("fields of the other frame kind not zero");

endmodule

bind sensor_frame_parser_unit sfp_checker u_sfp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .rx_byte     (rx_byte),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .frame_kind  (frame_kind),
  .left_count  (left_count),
  .right_count (right_count),
  .heading_raw (heading_raw),
  .range_0     (range_0),
  .range_1     (range_1),
  .range_2     (range_2),
  .range_3     (range_3),
  .range_4     (range_4),
  .range_5     (range_5),
  .range_6     (range_6),
  .range_7     (range_7)
);

`default_nettype wire
